>>> hdl/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg
// Shared types and constants of the period-capture tachometer.
// ----------------------------------------------------------------------------
package ctb_pkg;

    // Timer geometry
    localparam int TIMER_BITS = 16;
    localparam int CAP_W      = 16;
    localparam int OVF_W      = 16;
    localparam int ELAPSED_W  = TIMER_BITS + OVF_W + 1;

    localparam logic [ELAPSED_W-1:0] TIMER_MAX =
        ELAPSED_W'((64'd1 << TIMER_BITS) - 64'd1);
    localparam logic [CAP_W-1:0] CAP_MASK  = CAP_W'(TIMER_MAX);
    localparam logic [OVF_W-1:0] OVF_LIMIT = '1;

    // Divider and scaling
    localparam int DIV_W       = 32;
    localparam int DIV_STEPS   = DIV_W;
    localparam int CNT_W       = $clog2(DIV_STEPS);
    localparam int MUL_W       = 2 * DIV_W;
    // floor(q / 100) == (q * RECIP_100) >> RECIP_SHIFT for any 32-bit q
    localparam logic [DIV_W-1:0] RECIP_100 = 32'h51EB851F;
    localparam int RECIP_SHIFT = 37;
    localparam int FREQ_W      = MUL_W - RECIP_SHIFT;
    localparam int SCALE_W     = 7;
    localparam int PROD_W      = FREQ_W + SCALE_W;

    // Register reset values
    localparam logic [31:0]        CORE_CLOCK_RST = 32'd168000000;
    localparam logic [SCALE_W-1:0] RPM_PER_HZ_RST = 7'd20;
    localparam logic [31:0]        LOW_LIMIT_RST  = 32'd1000;
    localparam logic [31:0]        HIGH_LIMIT_RST = 32'd5000;

    // Event codes
    localparam logic OP_OVERFLOW = 1'b0;
    localparam logic OP_CAPTURE  = 1'b1;

    typedef enum logic [1:0] {
        CFG_CORE_CLOCK = 2'd0,
        CFG_RPM_PER_HZ = 2'd1,
        CFG_LOW_LIMIT  = 2'd2,
        CFG_HIGH_LIMIT = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        BAND_LOW  = 2'd0,
        BAND_MID  = 2'd1,
        BAND_HIGH = 2'd2,
        BAND_NONE = 2'd3
    } t_band;

    typedef struct packed {
        logic             op;
        logic [CAP_W-1:0] capture_value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] rpm;
        t_band       speed_band;
        logic        zero_period;
    } t_out_item;

    // Controller -> datapath
    typedef struct packed {
        logic ovf_inc;
        logic first_load;
        logic second_load;
        logic sum;
        logic div_init;
        logic set_zero;
        logic div_step;
        logic recip;
        logic scale;
        logic saturate;
        logic load_out;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic awaiting;
        logic elapsed_zero;
        logic out_busy;
    } t_status;

endpackage

>>> hdl/capture_tachometer_rpm_band.sv
// ----------------------------------------------------------------------------
// capture_tachometer_rpm_band
// Period-capture tachometer: rpm from two timer captures, with a speed band.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall, payload i_in_item): one timer event
// per item, either an overflow tick or an edge capture. Overflow ticks and
// first captures are absorbed without a stall and give no result. A second
// capture gives one result on the output channel (o_out_valid / i_out_stall,
// payload o_out_item).
// A second capture is worked by the 32-step restoring divider followed by the
// reciprocal /100 multiply, the rpm scaling multiply and saturation. A zero
// period skips the divider.
// The input stalls while a second capture is being worked; the next item is
// taken the cycle after the result enters the output register.
// If the receiver stalls, the result holds in the output register while the
// block keeps taking items; a following result waits in the sequencer until
// the register is free.
// Configuration (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data) is
// always ready; it must be written while idle, which the block does not check.
// Reset (synchronous, active low) loads the default registers, clears the
// capture state and empties the output register.
// ----------------------------------------------------------------------------
module capture_tachometer_rpm_band (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ctb_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ctb_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  ctb_pkg::t_cfg_index i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import ctb_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    ctb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_item.op),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    ctb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_write (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

>>> hdl/ctb_ctrl.sv
// ----------------------------------------------------------------------------
// ctb_ctrl
// Sequencer: takes events, steps the datapath through elapsed count,
// division, scaling and result hand-off.
// ----------------------------------------------------------------------------
module ctb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_op,
    input  ctb_pkg::t_status i_status,
    output logic            o_in_stall,
    output ctb_pkg::t_cmd   o_cmd
);
    import ctb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_CHECK,
        S_DIV,
        S_RECIP,
        S_SCALE,
        S_SAT,
        S_FINISH
    } t_state;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_in_stall;
    logic             in_fire;

    assign in_fire    = i_in_valid && !r_in_stall;
    assign o_in_stall = r_in_stall;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_op == OP_OVERFLOW) begin
                        o_cmd.ovf_inc = 1'b1;
                    end else if (!i_status.awaiting) begin
                        o_cmd.first_load = 1'b1;
                    end else begin
                        o_cmd.second_load = 1'b1;
                        n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_CHECK;
            end
            S_CHECK: begin
                // skip the division on an empty period
                if (i_status.elapsed_zero) begin
                    o_cmd.set_zero = 1'b1;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_RECIP;
                end
            end
            S_RECIP: begin
                o_cmd.recip = 1'b1;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state = S_SAT;
            end
            S_SAT: begin
                o_cmd.saturate = 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                // hold until the output register can take the item
                if (!i_status.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_in_stall <= (n_state != S_IDLE);
        end
    end

endmodule

>>> hdl/ctb_dp.sv
// ----------------------------------------------------------------------------
// ctb_dp
// Datapath: configuration registers, capture state, elapsed count,
// restoring divider, scaling, band compare and output register.
// ----------------------------------------------------------------------------
module ctb_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_write,
    input  ctb_pkg::t_cfg_index i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  ctb_pkg::t_in_item   i_in_item,
    input  ctb_pkg::t_cmd       i_cmd,
    output ctb_pkg::t_status    o_status,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ctb_pkg::t_out_item  o_out_item
);
    import ctb_pkg::*;

    // configuration
    logic [31:0]        r_core_clock;
    logic [SCALE_W-1:0] r_rpm_per_hz;
    logic [31:0]        r_low_limit;
    logic [31:0]        r_high_limit;

    // capture state
    logic               r_awaiting;
    logic [CAP_W-1:0]   r_first;
    logic [OVF_W-1:0]   r_ovf;

    // work registers
    logic [CAP_W-1:0]     r_second;
    logic [ELAPSED_W-1:0] r_ovf_prod;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic [DIV_W-1:0]     r_quo;
    logic [ELAPSED_W-1:0] r_rem;
    logic [MUL_W-1:0]     r_mul;
    logic [31:0]          r_rpm;
    logic                 r_zero;

    logic                 r_out_valid;
    t_out_item            r_out;

    logic [CAP_W-1:0]     cap_m;
    logic [ELAPSED_W-1:0] a_w, b_w, elapsed_c;
    logic [ELAPSED_W:0]   rem_sh, rem_diff;
    logic                 quo_bit;
    logic [ELAPSED_W-1:0] rem_next;
    logic [MUL_W-1:0]     recip_c;
    logic [FREQ_W-1:0]    freq;
    logic [PROD_W-1:0]    prod_c;
    t_band                band_c;

    assign cap_m = i_in_item.capture_value & CAP_MASK;

    // elapsed count with the wrap rule
    always_comb begin
        a_w = ELAPSED_W'(r_first);
        b_w = ELAPSED_W'(r_second);
        if (b_w > a_w) begin
            elapsed_c = b_w - a_w;
        end else if (b_w < a_w) begin
            elapsed_c = (TIMER_MAX - a_w) + b_w + r_ovf_prod;
        end else begin
            elapsed_c = '0;
        end
    end

    // one restoring step: shift in a dividend bit, subtract when it fits
    assign rem_sh   = {r_rem, r_quo[DIV_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_elapsed};
    assign quo_bit  = !rem_diff[ELAPSED_W];
    assign rem_next = quo_bit ? rem_diff[ELAPSED_W-1:0] : rem_sh[ELAPSED_W-1:0];

    assign recip_c = MUL_W'(r_quo) * MUL_W'(RECIP_100);
    assign freq    = r_mul[MUL_W-1:RECIP_SHIFT];
    assign prod_c  = PROD_W'(freq) * PROD_W'(r_rpm_per_hz);

    always_comb begin
        if (r_rpm < r_low_limit) begin
            band_c = BAND_LOW;
        end else if (r_rpm > r_low_limit && r_rpm < r_high_limit) begin
            band_c = BAND_MID;
        end else if (r_rpm > r_high_limit) begin
            band_c = BAND_HIGH;
        end else begin
            band_c = BAND_NONE;
        end
    end

    // configuration and capture state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_clock <= CORE_CLOCK_RST;
            r_rpm_per_hz <= RPM_PER_HZ_RST;
            r_low_limit  <= LOW_LIMIT_RST;
            r_high_limit <= HIGH_LIMIT_RST;
            r_awaiting   <= 1'b0;
            r_first      <= '0;
            r_ovf        <= '0;
        end else begin
            if (i_cfg_write) begin
                case (i_cfg_index)
                    CFG_CORE_CLOCK: r_core_clock <= i_cfg_data;
                    CFG_RPM_PER_HZ: r_rpm_per_hz <= i_cfg_data[SCALE_W-1:0];
                    CFG_LOW_LIMIT:  r_low_limit  <= i_cfg_data;
                    CFG_HIGH_LIMIT: r_high_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.ovf_inc && r_awaiting && r_ovf != OVF_LIMIT) begin
                r_ovf <= r_ovf + 1'b1;
            end
            if (i_cmd.first_load) begin
                r_first    <= cap_m;
                r_awaiting <= 1'b1;
            end
            if (i_cmd.second_load) begin
                r_awaiting <= 1'b0;
                r_ovf      <= '0;
            end
        end
    end

    // arithmetic pipeline, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.second_load) begin
            r_second   <= cap_m;
            r_ovf_prod <= ELAPSED_W'(r_ovf) * TIMER_MAX;
        end
        if (i_cmd.sum) begin
            r_elapsed <= elapsed_c;
        end
        if (i_cmd.div_init) begin
            r_quo  <= r_core_clock;
            r_rem  <= '0;
            r_zero <= 1'b0;
        end
        if (i_cmd.set_zero) begin
            r_rpm  <= '0;
            r_zero <= 1'b1;
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[DIV_W-2:0], quo_bit};
            r_rem <= rem_next;
        end
        if (i_cmd.recip) begin
            r_mul <= recip_c;
        end
        if (i_cmd.scale) begin
            r_mul <= MUL_W'(prod_c);
        end
        if (i_cmd.saturate) begin
            r_rpm <= (r_mul[MUL_W-1:32] != '0) ? '1 : r_mul[31:0];
        end
        if (i_cmd.load_out) begin
            r_out.rpm         <= r_rpm;
            r_out.speed_band  <= band_c;
            r_out.zero_period <= r_zero;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.awaiting     = r_awaiting;
    assign o_status.elapsed_zero = (r_elapsed == '0);
    assign o_status.out_busy     = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !(r_out_valid && i_out_stall))
        else $error("result loaded over a stalled item");

    a_ovf_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_awaiting |-> (r_ovf == '0))
        else $error("overflow count nonzero while waiting for first capture");

    a_zero_rpm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.zero_period) |-> (r_out.rpm == '0))
        else $error("zero period item with nonzero rpm");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the period-capture tachometer.
// Drives timer events (overflow ticks and edge captures) with random gaps,
// stalls the result side at random and predicts every rpm reading, speed band
// and zero-period flag from a behavioral model kept in a small scoreboard.
// Directed cases come first, then random capture pairs under changing settings.
// ----------------------------------------------------------------------------
module tb;
    import ctb_pkg::*;

    localparam logic [63:0] TICK_SPAN = 64'hFFFF;
    localparam logic [15:0] OVF_CAP   = 16'hFFFF;
    localparam int          SETTLE    = 45;

    class rpm_scoreboard;
        logic [31:0] core_hz;
        logic [6:0]  hz_scale;
        logic [31:0] low_lim;
        logic [31:0] high_lim;
        logic        awaiting;
        logic [15:0] first_cap;
        logic [15:0] ovf_cnt;
        t_out_item   due_readings[$];
        int          errors;
        int          taken;

        function new();
            core_hz   = CORE_CLOCK_RST;
            hz_scale  = RPM_PER_HZ_RST;
            low_lim   = LOW_LIMIT_RST;
            high_lim  = HIGH_LIMIT_RST;
            awaiting  = 1'b0;
            first_cap = '0;
            ovf_cnt   = '0;
            errors    = 0;
            taken     = 0;
        endfunction

        function void set_reg(t_cfg_index idx, logic [31:0] data);
            case (idx)
                CFG_CORE_CLOCK: core_hz  = data;
                CFG_RPM_PER_HZ: hz_scale = data[6:0];
                CFG_LOW_LIMIT:  low_lim  = data;
                CFG_HIGH_LIMIT: high_lim = data;
                default: ;
            endcase
        endfunction

        function void note_event(t_in_item ev);
            logic [63:0] a;
            logic [63:0] b;
            logic [63:0] elapsed;
            logic [63:0] freq;
            logic [63:0] prod;
            t_out_item   r;
            if (ev.op == OP_OVERFLOW) begin
                // ticks only count while a second capture is pending
                if (awaiting) begin
                    taken++;
                    if (ovf_cnt != OVF_CAP) ovf_cnt++;
                end
                return;
            end
            taken++;
            if (!awaiting) begin
                first_cap = ev.capture_value;
                awaiting  = 1'b1;
                return;
            end
            a = {48'b0, first_cap};
            b = {48'b0, ev.capture_value};
            if (b > a) begin
                elapsed = b - a;
            end else if (b < a) begin
                elapsed = (TICK_SPAN - a) + b + {48'b0, ovf_cnt} * TICK_SPAN;
            end else begin
                elapsed = '0;
            end
            if (elapsed == 0) begin
                r.rpm         = '0;
                r.zero_period = 1'b1;
            end else begin
                freq = ({32'b0, core_hz} / elapsed) / 64'd100;
                prod = freq * {57'b0, hz_scale};
                r.rpm         = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
                r.zero_period = 1'b0;
            end
            // tests run in this order even when the limits are swapped
            if (r.rpm < low_lim) begin
                r.speed_band = BAND_LOW;
            end else if (r.rpm > low_lim && r.rpm < high_lim) begin
                r.speed_band = BAND_MID;
            end else if (r.rpm > high_lim) begin
                r.speed_band = BAND_HIGH;
            end else begin
                r.speed_band = BAND_NONE;
            end
            awaiting = 1'b0;
            ovf_cnt  = '0;
            due_readings.push_back(r);
        endfunction

        function void check_reading(t_out_item got);
            t_out_item want;
            if (due_readings.size() == 0) begin
                errors++;
                $display("%0t: reading with none expected: rpm %0d band %0d zero %0d",
                         $time, got.rpm, got.speed_band, got.zero_period);
                return;
            end
            want = due_readings.pop_front();
            if (got.rpm !== want.rpm) begin
                errors++;
                $display("%0t: rpm mismatch: expected %0d, got %0d",
                         $time, want.rpm, got.rpm);
            end
            if (got.speed_band !== want.speed_band) begin
                errors++;
                $display("%0t: speed_band mismatch: expected %0d, got %0d",
                         $time, want.speed_band, got.speed_band);
            end
            if (got.zero_period !== want.zero_period) begin
                errors++;
                $display("%0t: zero_period mismatch: expected %0d, got %0d",
                         $time, want.zero_period, got.zero_period);
            end
        endfunction

        function int pending();
            return due_readings.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_index  i_cfg_index;
    logic [31:0] i_cfg_data;

    rpm_scoreboard sb;
    int            tx_idle_pct;
    int            rx_idle_pct;

    capture_tachometer_rpm_band dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // result side: check accepted readings, then pick next cycle's stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_reading(o_out_item);
        end
        i_out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // leave valid high on return; the next call or drain() decides what follows
    task automatic send_event(input t_in_item ev);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= ev;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_event(ev);
    endtask

    task automatic send_capture(input logic [15:0] v);
        t_in_item ev;
        ev.op            = OP_CAPTURE;
        ev.capture_value = v;
        send_event(ev);
    endtask

    task automatic send_tick();
        t_in_item ev;
        ev.op            = OP_OVERFLOW;
        ev.capture_value = 16'($urandom);
        send_event(ev);
    endtask

    task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input int ticks);
        send_capture(a);
        repeat (ticks) send_tick();
        send_capture(b);
    endtask

    // drop valid, wait out every pending reading and any trailing work
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task automatic load_settings(input logic [31:0] clk_hz, input logic [31:0] scale,
                                 input logic [31:0] lo, input logic [31:0] hi);
        write_reg(CFG_CORE_CLOCK, clk_hz);
        write_reg(CFG_RPM_PER_HZ, scale);
        write_reg(CFG_LOW_LIMIT, lo);
        write_reg(CFG_HIGH_LIMIT, hi);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(9))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(0, 20000);
        endcase
    endfunction

    task automatic random_settings();
        logic [31:0] clk_hz;
        case ($urandom_range(4))
            0:       clk_hz = $urandom;
            1:       clk_hz = CORE_CLOCK_RST;
            2:       clk_hz = ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'd1;
            default: clk_hz = $urandom_range(1, 200000000);
        endcase
        load_settings(clk_hz, $urandom, pick_limit(), pick_limit());
    endtask

    function automatic logic [15:0] pick_capture();
        case ($urandom_range(19))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly clean first/second pairs; the rest stray ticks and lone captures
    task automatic random_sequence();
        logic [15:0] a;
        logic [15:0] b;
        int          ticks;
        int          r;
        r = $urandom_range(99);
        if (r < 80) begin
            a = pick_capture();
            case ($urandom_range(9))
                0:       b = a;
                1, 2, 3: b = a + 16'($urandom_range(1, 200));
                default: b = pick_capture();
            endcase
            ticks = ($urandom_range(9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 2);
            send_pair(a, b, ticks);
        end else if (r < 90) begin
            send_tick();
        end else begin
            send_capture(pick_capture());
        end
    endtask

    initial begin
        int ph;
        int blk;
        int start;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_CORE_CLOCK;
        i_cfg_data  = '0;
        tx_idle_pct = 31;
        rx_idle_pct = 71;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default settings: ignored tick, full span, wrap to zero, equal values
        send_tick();
        send_pair(16'h0000, 16'hFFFF, 0);
        send_pair(16'hFFFF, 16'h0000, 0);
        send_pair(16'd100, 16'd100, 0);
        send_pair(16'd1000, 16'd500, 3);
        send_pair(16'd0, 16'd1, 0);
        // long overflow run across a wrap, without gaps
        tx_idle_pct = 0;
        send_pair(16'd5, 16'd3, 20);
        tx_idle_pct = 31;
        drain();

        // rpm lands exactly on a limit
        load_settings(32'd100000, 32'd1, 32'd1000, 32'd5000);
        send_pair(16'd0, 16'd1, 0);
        send_pair(16'd0, 16'd2, 0);
        drain();
        load_settings(32'd100000, 32'd1, 32'd0, 32'd1000);
        send_pair(16'd0, 16'd1, 0);
        drain();
        // swapped limits
        load_settings(32'd100000, 32'd1, 32'd500, 32'd100);
        send_pair(16'd0, 16'd1, 0);
        drain();
        // saturating product, then zero period against a zero low limit
        load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        send_pair(16'd0, 16'd1, 0);
        send_pair(16'd7, 16'd7, 0);
        drain();
        // zero clock and zero multiplier
        load_settings(32'd0, 32'd0, 32'd1, 32'd2);
        send_pair(16'd0, 16'd1, 0);
        drain();

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0:       begin tx_idle_pct = 31; rx_idle_pct = 71; end
                1:       begin tx_idle_pct = 71; rx_idle_pct = 31; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            for (blk = 0; blk < 5; blk++) begin
                random_settings();
                start = sb.taken;
                while (sb.taken - start < 56) random_sequence();
                drain();
            end
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
hdl/ctb_pkg.sv
hdl/ctb_ctrl.sv
hdl/ctb_dp.sv
hdl/capture_tachometer_rpm_band.sv
verif/tb.sv
